[rtl/core/jrcs_pkg.sv]
// shared types, character codes and register indexes for the json row chunk splitter
package jrcs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;
    localparam int ROWS_MIN_W = 16;
    localparam int COUNT_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ARRAY_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CHUNK_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CHUNK_ROWS  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] MIN_BYTES_RST = 28'd10485760;
    localparam logic [ROWS_MIN_W-1:0] MIN_ROWS_RST  = 16'd1;

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_VT      = 8'h0B;

    typedef struct packed {
        logic                  array_mode;
        logic [CFG_DATA_W-1:0] min_bytes;
        logic [ROWS_MIN_W-1:0] row_target;
        logic                  bytes_nz;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         byte_out;
        logic               byte_kept;
        logic               chunk_end;
        logic [COUNT_W-1:0] rows_in_chunk;
        logic               oversize_error;
        logic               underflow_error;
    } res_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
    endfunction

endpackage

[rtl/core/jrcs_cfg.sv]
// configuration registers and the precomputed oversize limit
module jrcs_cfg #(
    parameter int OVERSIZE_FACTOR = 10,
    parameter int LIMIT_W         = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [jrcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jrcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output jrcs_pkg::cfg_t                     cfg,
    output logic [LIMIT_W-1:0]                 limit
);
    import jrcs_pkg::*;

    localparam logic [LIMIT_W-1:0] FACTOR    = LIMIT_W'(OVERSIZE_FACTOR);
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(MIN_BYTES_RST) * FACTOR;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;

    always_comb
    begin
        cfg_next   = cfg_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ARRAY_MODE:
                begin
                    cfg_next.array_mode = cfg_wdata[0];
                end
                REG_MIN_CHUNK_BYTES:
                begin
                    cfg_next.min_bytes = cfg_wdata;
                    cfg_next.bytes_nz  = (cfg_wdata != '0);
                    // x FACTOR; user writes only when block idle, unchecked
                    limit_next         = LIMIT_W'(cfg_wdata) * FACTOR;
                end
                REG_MIN_CHUNK_ROWS:
                begin
                    cfg_next.row_target = cfg_wdata[ROWS_MIN_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.array_mode <= 1'b0;
            cfg_reg.min_bytes  <= MIN_BYTES_RST;
            cfg_reg.row_target <= MIN_ROWS_RST;
            cfg_reg.bytes_nz   <= 1'b1;
            limit_reg          <= LIMIT_RST;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            limit_reg <= limit_next;
        end
    end

    assign cfg   = cfg_reg;
    assign limit = limit_reg;

endmodule

[rtl/core/jrcs_scan.sv]
// scanner state (depth, string, escape, counts) and the per-word result logic
module jrcs_scan #(
    parameter int LIMIT_W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 stream_end,
    input  jrcs_pkg::cfg_t       cfg,
    input  logic [LIMIT_W-1:0]   limit,
    output jrcs_pkg::res_t       res
);
    import jrcs_pkg::*;

    localparam int CMP_W = (LIMIT_W > COUNT_W) ? LIMIT_W : COUNT_W;

    logic [COUNT_W-1:0] depth_reg;
    logic [COUNT_W-1:0] depth_next;
    logic               in_str_reg;
    logic               in_str_next;
    logic               esc_reg;
    logic               esc_next;
    logic [COUNT_W-1:0] bytes_reg;
    logic [COUNT_W-1:0] bytes_next;
    logic [COUNT_W-1:0] rows_reg;
    logic [COUNT_W-1:0] rows_next;
    logic               start_reg;
    logic               start_next;

    logic [7:0] open_ch;
    logic [7:0] close_ch;
    logic       skip;
    logic       row_done;
    logic       underflow;
    logic       chunk_end;
    logic       oversize;

    assign open_ch  = cfg.array_mode ? CH_LBRACK : CH_LBRACE;
    assign close_ch = cfg.array_mode ? CH_RBRACK : CH_RBRACE;
    assign skip     = start_reg && is_space(data_byte);

    always_comb
    begin
        depth_next  = depth_reg;
        in_str_next = in_str_reg;
        esc_next    = esc_reg;
        bytes_next  = bytes_reg;
        rows_next   = rows_reg;
        start_next  = start_reg;
        row_done    = 1'b0;
        underflow   = 1'b0;
        if (!skip)
        begin
            start_next = 1'b0;
            if (bytes_reg != '1)
            begin
                bytes_next = bytes_reg + COUNT_W'(1);
            end
            if (esc_reg)
            begin
                esc_next = 1'b0;
            end
            else if (data_byte == CH_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (in_str_reg)
            begin
                if (data_byte == CH_QUOTE)
                begin
                    in_str_next = 1'b0;
                end
            end
            else if (data_byte == CH_QUOTE)
            begin
                in_str_next = 1'b1;
            end
            else if (data_byte == open_ch)
            begin
                if (depth_reg != '1)
                begin
                    depth_next = depth_reg + COUNT_W'(1);
                end
            end
            else if (data_byte == close_ch)
            begin
                if (depth_reg == '0)
                begin
                    underflow = 1'b1;
                end
                else
                begin
                    depth_next = depth_reg - COUNT_W'(1);
                    // closing bracket of a top-level row
                    if (depth_reg == COUNT_W'(1))
                    begin
                        row_done = 1'b1;
                        if (rows_reg != '1)
                        begin
                            rows_next = rows_reg + COUNT_W'(1);
                        end
                    end
                end
            end
        end
        oversize  = cfg.bytes_nz && (CMP_W'(bytes_next) > CMP_W'(limit));
        chunk_end = stream_end ||
                    (row_done && (bytes_next >= COUNT_W'(cfg.min_bytes)) &&
                     (rows_next >= COUNT_W'(cfg.row_target)));
    end

    always_comb
    begin
        res.byte_out        = data_byte;
        res.byte_kept       = !skip;
        res.chunk_end       = chunk_end;
        res.rows_in_chunk   = rows_next;
        res.oversize_error  = oversize;
        res.underflow_error = underflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            in_str_reg <= 1'b0;
            esc_reg    <= 1'b0;
            bytes_reg  <= '0;
            rows_reg   <= '0;
            start_reg  <= 1'b1;
        end
        else if (step)
        begin
            if (chunk_end)
            begin
                depth_reg  <= '0;
                in_str_reg <= 1'b0;
                esc_reg    <= 1'b0;
                bytes_reg  <= '0;
                rows_reg   <= '0;
                start_reg  <= 1'b1;
            end
            else
            begin
                depth_reg  <= depth_next;
                in_str_reg <= in_str_next;
                esc_reg    <= esc_next;
                bytes_reg  <= bytes_next;
                rows_reg   <= rows_next;
                start_reg  <= start_next;
            end
        end
    end

endmodule

[rtl/core/json_row_chunk_splitter.sv]
// top level: input register, scanner, result register and configuration port
//
//  channel | signals                                      | moves
//  --------+----------------------------------------------+---------------------------
//  in      | in_valid/in_ready, data_byte, stream_end     | one stream byte per word
//  out     | out_valid/out_ready, byte_out .. underflow   | one result word per byte
//  cfg     | cfg_we, cfg_index, cfg_wdata                 | register write, no wait
//
// one word per cycle sustained while out_ready is high; an accepted word passes the
// input register, then scanner logic into the result register, which sets out_valid
// the scanner state (depth, counts, flags) is updated from its own registers for each word
// reset clears all valid bits and the scanner state; config returns to defaults
// a stalled output holds its word while one more word waits in the input register
module json_row_chunk_splitter #(
    parameter int OVERSIZE_FACTOR = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            stream_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      byte_out,
    output logic                            byte_kept,
    output logic                            chunk_end,
    output logic [jrcs_pkg::COUNT_W-1:0]    rows_in_chunk,
    output logic                            oversize_error,
    output logic                            underflow_error,
    input  logic                            cfg_we,
    input  logic [jrcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jrcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import jrcs_pkg::*;

    localparam int LIMIT_W = CFG_DATA_W + $clog2(OVERSIZE_FACTOR + 1);

    cfg_t               cfg;
    logic [LIMIT_W-1:0] limit;
    res_t               res;

    logic       inq_valid_reg;
    logic       inq_valid_next;
    logic [7:0] inq_byte_reg;
    logic       inq_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       out_reg;
    logic       advance;

    assign advance  = inq_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !inq_valid_reg || advance;

    jrcs_cfg #(
        .OVERSIZE_FACTOR (OVERSIZE_FACTOR),
        .LIMIT_W         (LIMIT_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .limit     (limit)
    );

    jrcs_scan #(
        .LIMIT_W (LIMIT_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (inq_byte_reg),
        .stream_end (inq_last_reg),
        .cfg        (cfg),
        .limit      (limit),
        .res        (res)
    );

    always_comb
    begin
        inq_valid_next = inq_valid_reg;
        if (in_valid && in_ready)
        begin
            inq_valid_next = 1'b1;
        end
        else if (advance)
        begin
            inq_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            inq_valid_reg <= inq_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            inq_byte_reg <= data_byte;
            inq_last_reg <= stream_end;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign byte_out        = out_reg.byte_out;
    assign byte_kept       = out_reg.byte_kept;
    assign chunk_end       = out_reg.chunk_end;
    assign rows_in_chunk   = out_reg.rows_in_chunk;
    assign oversize_error  = out_reg.oversize_error;
    assign underflow_error = out_reg.underflow_error;

endmodule

[rtl/core/jrcs_checker.sv]
// port-level checks for the json row chunk splitter, bound to the top level
module jrcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] byte_out,
    input logic       byte_kept,
    input logic       chunk_end,
    input logic       underflow_error
);
    import jrcs_pkg::*;

    // a stalled result word holds its byte, byte_kept and chunk_end
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_out) &&
                                    $stable(chunk_end) && $stable(byte_kept))
        else $error("result word changed while stalled");

    // only whitespace is ever dropped
    a_skip_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_kept |-> is_space(byte_out))
        else $error("non-whitespace byte dropped");

    // a dropped byte cannot be an unmatched closing bracket
    a_underflow_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && underflow_error |-> byte_kept &&
            (byte_out == CH_RBRACE || byte_out == CH_RBRACK))
        else $error("underflow on a dropped or non-bracket byte");

    // no result word comes straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid at reset release");

endmodule

bind json_row_chunk_splitter jrcs_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .byte_out        (byte_out),
    .byte_kept       (byte_kept),
    .chunk_end       (chunk_end),
    .underflow_error (underflow_error)
);
